// File: rtl/pbtt_pkg.sv
`timescale 1ns / 1ps
package pbtt_pkg;

  localparam int THREADS    = 64;
  localparam int ADDR_W     = $clog2(THREADS);
  localparam int TID_W      = 6;
  localparam int FUNC_W     = 3;
  localparam int PRIO_W     = 10;
  localparam int QUANT_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [FUNC_W-1:0] {
    FN_INIT      = 3'd0,
    FN_CLEAR     = 3'd1,
    FN_SEND      = 3'd2,
    FN_RECV_MISS = 3'd3,
    FN_RECV_HIT  = 3'd4,
    FN_QUERY     = 3'd5,
    FN_EXECUTE   = 3'd6,
    FN_COPY      = 3'd7
  } func_t;

  localparam logic [CFG_IDX_W-1:0] CFG_BEST_PRIO   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WORST_PRIO  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_PRIO   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RECV_FIRST  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RECV_LAST   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SENDER_LAST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM     = 3'd6;

  localparam logic signed [PRIO_W-1:0] BEST_PRIO_RST  = 10'sd0;
  localparam logic signed [PRIO_W-1:0] WORST_PRIO_RST = 10'sd100;
  localparam logic signed [PRIO_W-1:0] BASE_PRIO_RST  = 10'sd50;
  localparam logic [QUANT_W-1:0]       QUANTUM_RST    = 32'd10000;

endpackage

// File: rtl/pbtt_in_if.sv
`timescale 1ns / 1ps
interface pbtt_in_if;
  import pbtt_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic [TID_W-1:0]         thread_id;
  logic [TID_W-1:0]         dest_thread;
  logic signed [PRIO_W-1:0] init_priority;
  logic [QUANT_W-1:0]       work_left;
  logic                     lost_cpu;

  modport source (output valid, func, thread_id, dest_thread, init_priority, work_left,
                  lost_cpu, input ready);
  modport sink (input valid, func, thread_id, dest_thread, init_priority, work_left,
                lost_cpu, output ready);
endinterface

// File: rtl/pbtt_out_if.sv
`timescale 1ns / 1ps
interface pbtt_out_if;
  import pbtt_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [PRIO_W-1:0] priority_out;
  logic [QUANT_W-1:0]       slice_time;
  logic [QUANT_W-1:0]       work_after;
  logic                     work_done;
  logic                     prio_changed;

  modport source (output valid, priority_out, slice_time, work_after, work_done,
                  prio_changed, input ready);
  modport sink (input valid, priority_out, slice_time, work_after, work_done,
                prio_changed, output ready);
endinterface

// File: rtl/pbtt_cfg_if.sv
`timescale 1ns / 1ps
interface pbtt_cfg_if;
  import pbtt_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, idx, data, input ready);
  modport sink (input valid, idx, data, output ready);
endinterface

// File: rtl/pbtt_ram.sv
`timescale 1ns / 1ps
module pbtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/priority_boost_thread_table_core.sv
`timescale 1ns / 1ps
// Channel   Role  Handshake     Word
// in_ch     sink  valid/ready   func, thread_id, dest_thread, init_priority, work_left,
//                               lost_cpu
// out_ch    src   valid/ready   priority_out, slice_time, work_after, work_done,
//                               prio_changed
// cfg_ch    sink  valid/ready   idx, data (ready always high)
//
// One word per cycle unless out_ch stalls; each word passes s1, then the output register.
// Tables sit in two registered-read RAMs: read at accept, written in the compute
// cycle; a write landing at the accept edge is forwarded to the reader.
// rst_n (synchronous) clears config to defaults and the pipeline; tables stay undefined.
// A stalled out_ch holds the compute stage, which then holds in_ch.ready low.
module priority_boost_thread_table_core (
  input  logic clk,
  input  logic rst_n,
  pbtt_in_if.sink    in_ch,
  pbtt_out_if.source out_ch,
  pbtt_cfg_if.sink   cfg_ch
);
  import pbtt_pkg::*;

  logic signed [PRIO_W-1:0] best_prio_r, worst_prio_r, base_prio_r;
  logic signed [PRIO_W-1:0] recv_first_r, recv_last_r, sender_last_r;
  logic [QUANT_W-1:0]       quantum_r;

  logic                     s1_valid_r;
  func_t                    s1_func_r;
  logic [TID_W-1:0]         s1_tid_r, s1_dest_r;
  logic signed [PRIO_W-1:0] s1_initp_r;
  logic [QUANT_W-1:0]       s1_work_r;
  logic                     s1_lost_r;

  logic                     byp_prio_hit_r, byp_used_hit_r;
  logic signed [PRIO_W-1:0] byp_prio_r;
  logic [QUANT_W-1:0]       byp_used_r;

  logic                     out_valid_r;
  logic signed [PRIO_W-1:0] out_prio_r;
  logic [QUANT_W-1:0]       out_slice_r, out_after_r;
  logic                     out_done_r, out_changed_r;

  logic                     in_accept, in_ready, s1_adv;
  logic [ADDR_W-1:0]        rd_addr, wr_addr;
  logic                     prio_we, used_we;
  logic signed [PRIO_W-1:0] prio_wdata, prio_rdata, cur_prio;
  logic [QUANT_W-1:0]       used_wdata, used_rdata, old_used;

  logic                     in_range;
  logic signed [PRIO_W-1:0] boost;
  logic signed [PRIO_W:0]   sum, best_ext, worst_ext, lo_clamp, hi_clamp;
  logic signed [PRIO_W-1:0] boosted;
  logic                     fresh;
  logic [QUANT_W-1:0]       left, limit, ex, used_new;

  logic signed [PRIO_W-1:0] prio_nxt;
  logic [QUANT_W-1:0]       slice_nxt, after_nxt;
  logic                     done_nxt, changed_nxt;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_prio_r   <= BEST_PRIO_RST;
      worst_prio_r  <= WORST_PRIO_RST;
      base_prio_r   <= BASE_PRIO_RST;
      recv_first_r  <= '0;
      recv_last_r   <= '0;
      sender_last_r <= '0;
      quantum_r     <= QUANTUM_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.idx)
        CFG_BEST_PRIO:   best_prio_r   <= cfg_ch.data[PRIO_W-1:0];
        CFG_WORST_PRIO:  worst_prio_r  <= cfg_ch.data[PRIO_W-1:0];
        CFG_BASE_PRIO:   base_prio_r   <= cfg_ch.data[PRIO_W-1:0];
        CFG_RECV_FIRST:  recv_first_r  <= cfg_ch.data[PRIO_W-1:0];
        CFG_RECV_LAST:   recv_last_r   <= cfg_ch.data[PRIO_W-1:0];
        CFG_SENDER_LAST: sender_last_r <= cfg_ch.data[PRIO_W-1:0];
        CFG_QUANTUM:     quantum_r     <= cfg_ch.data[QUANT_W-1:0];
        default: ;
      endcase
    end
  end

  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ready    = !s1_valid_r || s1_adv;
  assign in_ch.ready = in_ready;
  assign in_accept   = in_ch.valid && in_ready;
  assign rd_addr     = ADDR_W'(in_ch.thread_id);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_func_r      <= func_t'(in_ch.func);
      s1_tid_r       <= in_ch.thread_id;
      s1_dest_r      <= in_ch.dest_thread;
      s1_initp_r     <= in_ch.init_priority;
      s1_work_r      <= in_ch.work_left;
      s1_lost_r      <= in_ch.lost_cpu;
      byp_prio_hit_r <= prio_we && (wr_addr == rd_addr);
      byp_used_hit_r <= used_we && (wr_addr == rd_addr);
      byp_prio_r     <= prio_wdata;
      byp_used_r     <= used_wdata;
    end
  end

  pbtt_ram #(.WIDTH(PRIO_W), .DEPTH(THREADS)) u_prio_ram (
    .clk   (clk),
    .we    (prio_we),
    .waddr (wr_addr),
    .wdata (prio_wdata),
    .re    (in_accept),
    .raddr (rd_addr),
    .rdata (prio_rdata)
  );

  pbtt_ram #(.WIDTH(QUANT_W), .DEPTH(THREADS)) u_used_ram (
    .clk   (clk),
    .we    (used_we),
    .waddr (wr_addr),
    .wdata (used_wdata),
    .re    (in_accept),
    .raddr (rd_addr),
    .rdata (used_rdata)
  );

  assign cur_prio = byp_prio_hit_r ? byp_prio_r : prio_rdata;
  assign old_used = byp_used_hit_r ? byp_used_r : used_rdata;

  assign in_range = (32'(s1_tid_r) < THREADS) &&
                    ((s1_func_r != FN_COPY) || (32'(s1_dest_r) < THREADS));
  assign wr_addr  = (s1_func_r == FN_COPY) ? ADDR_W'(s1_dest_r) : ADDR_W'(s1_tid_r);

  always_comb begin
    unique case (s1_func_r)
      FN_SEND:      boost = sender_last_r;
      FN_RECV_MISS: boost = recv_first_r;
      default:      boost = recv_last_r;
    endcase
  end

  assign sum       = $signed({cur_prio[PRIO_W-1], cur_prio}) +
                     $signed({boost[PRIO_W-1], boost});
  assign best_ext  = $signed({best_prio_r[PRIO_W-1], best_prio_r});
  assign worst_ext = $signed({worst_prio_r[PRIO_W-1], worst_prio_r});
  assign lo_clamp  = (sum < best_ext) ? best_ext : sum;
  assign hi_clamp  = (lo_clamp > worst_ext) ? worst_ext : lo_clamp;
  assign boosted   = hi_clamp[PRIO_W-1:0];

  assign fresh    = s1_lost_r || (old_used == quantum_r);
  assign left     = (quantum_r > old_used) ? quantum_r - old_used : '0;
  assign limit    = fresh ? quantum_r : left;
  assign ex       = (s1_work_r < limit) ? s1_work_r : limit;
  assign used_new = fresh ? ex : old_used + ex;

  always_comb begin
    prio_we     = 1'b0;
    used_we     = 1'b0;
    prio_wdata  = cur_prio;
    used_wdata  = old_used;
    prio_nxt    = cur_prio;
    slice_nxt   = '0;
    after_nxt   = '0;
    done_nxt    = 1'b0;
    changed_nxt = 1'b0;
    unique case (s1_func_r) inside
      FN_INIT: begin
        prio_we    = 1'b1;
        used_we    = 1'b1;
        prio_wdata = s1_initp_r;
        used_wdata = '0;
        prio_nxt   = s1_initp_r;
      end
      FN_CLEAR: begin
        prio_we    = 1'b1;
        used_we    = 1'b1;
        prio_wdata = base_prio_r;
        used_wdata = '0;
        prio_nxt   = base_prio_r;
      end
      FN_SEND, FN_RECV_MISS, FN_RECV_HIT: begin
        prio_we     = 1'b1;
        prio_wdata  = boosted;
        prio_nxt    = boosted;
        changed_nxt = (boosted != cur_prio);
      end
      FN_EXECUTE: begin
        used_we    = 1'b1;
        used_wdata = used_new;
        slice_nxt  = ex;
        after_nxt  = s1_work_r - ex;
        done_nxt   = (s1_work_r == ex);
      end
      FN_COPY: begin
        prio_we = 1'b1;
        used_we = 1'b1;
      end
      default: ;
    endcase
    if (!in_range) begin
      prio_we     = 1'b0;
      used_we     = 1'b0;
      prio_nxt    = '0;
      slice_nxt   = '0;
      after_nxt   = '0;
      done_nxt    = 1'b0;
      changed_nxt = 1'b0;
    end
    if (!s1_adv) begin
      prio_we = 1'b0;
      used_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_prio_r    <= prio_nxt;
      out_slice_r   <= slice_nxt;
      out_after_r   <= after_nxt;
      out_done_r    <= done_nxt;
      out_changed_r <= changed_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.priority_out = out_prio_r;
  assign out_ch.slice_time   = out_slice_r;
  assign out_ch.work_after   = out_after_r;
  assign out_ch.work_done    = out_done_r;
  assign out_ch.prio_changed = out_changed_r;

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("compute stage advanced without filling output");

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> s1_valid_r)
    else $error("accepted word lost before compute stage");

  a_stall_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ch.ready))
    else $error("input stalled without a full pipeline");

  a_done_no_work: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_r) |-> (out_after_r == '0))
    else $error("work_done with work remaining");

  a_slice_in_quantum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_slice_r <= quantum_r))
    else $error("slice exceeds quantum");

endmodule

// File: verif/tb_priority_boost_thread_table_core.sv
`timescale 1ns / 1ps
module tb_priority_boost_thread_table_core;
  import pbtt_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 400;
  localparam int PHASE_ITEMS    = 200;

  typedef struct {
    func_t                    func;
    logic [TID_W-1:0]         thread_id;
    logic [TID_W-1:0]         dest_thread;
    logic signed [PRIO_W-1:0] init_priority;
    logic [QUANT_W-1:0]       work_left;
    logic                     lost_cpu;
  } thread_op_t;

  typedef struct {
    logic signed [PRIO_W-1:0] priority_out;
    logic [QUANT_W-1:0]       slice_time;
    logic [QUANT_W-1:0]       work_after;
    logic                     work_done;
    logic                     prio_changed;
  } thread_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pbtt_in_if  in_ch();
  pbtt_out_if out_ch();
  pbtt_cfg_if cfg_ch();

  priority_boost_thread_table_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic signed [PRIO_W-1:0] best_cfg, worst_cfg, base_cfg;
  logic signed [PRIO_W-1:0] recv_first_cfg, recv_last_cfg, sender_last_cfg;
  logic [QUANT_W-1:0]       quantum_cfg;

  logic signed [PRIO_W-1:0] prio_model [THREADS];
  logic [QUANT_W-1:0]       used_model [THREADS];

  bit  live [THREADS];
  int  live_cnt = 0;

  thread_op_t     op_q [$];
  thread_report_t report_q [$];
  thread_op_t     offered_op;
  thread_report_t want;

  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int fail_count = 0;

  function automatic thread_report_t apply_thread_op(input thread_op_t op);
    thread_report_t r;
    logic [TID_W-1:0] t;
    logic signed [PRIO_W-1:0] boost;
    logic signed [PRIO_W-1:0] old;
    logic [QUANT_W-1:0] used, work, ex, left;
    int p;
    r = '{default: '0};
    t = op.thread_id;
    work = op.work_left;
    case (op.func)
      FN_INIT: begin
        prio_model[t] = op.init_priority;
        used_model[t] = '0;
      end
      FN_CLEAR: begin
        prio_model[t] = base_cfg;
        used_model[t] = '0;
      end
      FN_SEND, FN_RECV_MISS, FN_RECV_HIT: begin
        boost = (op.func == FN_SEND) ? sender_last_cfg :
                (op.func == FN_RECV_MISS) ? recv_first_cfg : recv_last_cfg;
        old = prio_model[t];
        p = int'(old) + int'(boost);
        if (p < int'(best_cfg)) p = int'(best_cfg);
        if (p > int'(worst_cfg)) p = int'(worst_cfg);
        prio_model[t] = p[PRIO_W-1:0];
        r.prio_changed = (p != int'(old));
      end
      FN_EXECUTE: begin
        used = used_model[t];
        if (op.lost_cpu || used == quantum_cfg) begin
          ex = (work < quantum_cfg) ? work : quantum_cfg;
          used_model[t] = ex;
        end else begin
          left = (quantum_cfg > used) ? quantum_cfg - used : '0;
          ex = (left < work) ? left : work;
          used_model[t] = used + ex;
        end
        r.slice_time = ex;
        r.work_after = work - ex;
        r.work_done  = (work - ex) == '0;
      end
      FN_COPY: begin
        prio_model[op.dest_thread] = prio_model[t];
        used_model[op.dest_thread] = used_model[t];
        t = op.dest_thread;
      end
      default: ;
    endcase
    r.priority_out = prio_model[t];
    return r;
  endfunction

  function automatic thread_op_t make_op(input func_t func, input int tid, input int dest,
                                         input int prio, input logic [31:0] work,
                                         input bit lost);
    thread_op_t op;
    op.func          = func;
    op.thread_id     = TID_W'(tid);
    op.dest_thread   = TID_W'(dest);
    op.init_priority = PRIO_W'(prio);
    op.work_left     = work;
    op.lost_cpu      = lost;
    return op;
  endfunction

  function automatic void queue_op(input thread_op_t op);
    if ((op.func == FN_INIT || op.func == FN_CLEAR) && !live[op.thread_id]) begin
      live[op.thread_id] = 1'b1;
      live_cnt++;
    end
    if (op.func == FN_COPY && !live[op.dest_thread]) begin
      live[op.dest_thread] = 1'b1;
      live_cnt++;
    end
    op_q.push_back(op);
  endfunction

  function automatic logic [QUANT_W-1:0] pick_work();
    logic [QUANT_W-1:0] lim;
    lim = (quantum_cfg < 32'd1000000) ? quantum_cfg * 2 + 1 : quantum_cfg;
    case ($urandom_range(7))
      0: return '0;
      1: return $urandom;
      5: return quantum_cfg;
      6: return '1;
      7: return QUANT_W'($urandom_range(8, 1));
      default: return QUANT_W'($urandom_range(lim, 0));
    endcase
  endfunction

  function automatic thread_op_t random_op();
    thread_op_t op;
    op.func = func_t'(FUNC_W'($urandom_range(7)));
    if ($urandom_range(1) == 0) op.thread_id = TID_W'($urandom_range(3));
    else op.thread_id = TID_W'($urandom_range(THREADS - 1));
    op.dest_thread   = TID_W'($urandom_range(THREADS - 1));
    op.init_priority = PRIO_W'($urandom);
    op.work_left     = pick_work();
    op.lost_cpu      = 1'($urandom_range(1));
    if (op.func != FN_INIT && op.func != FN_CLEAR && !live[op.thread_id]) begin
      if (live_cnt == 0) begin
        op.func = FN_INIT;
      end else begin
        while (!live[op.thread_id]) op.thread_id = TID_W'($urandom_range(THREADS - 1));
      end
    end
    return op;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.idx   <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_BEST_PRIO:   best_cfg        = value[PRIO_W-1:0];
      CFG_WORST_PRIO:  worst_cfg       = value[PRIO_W-1:0];
      CFG_BASE_PRIO:   base_cfg        = value[PRIO_W-1:0];
      CFG_RECV_FIRST:  recv_first_cfg  = value[PRIO_W-1:0];
      CFG_RECV_LAST:   recv_last_cfg   = value[PRIO_W-1:0];
      CFG_SENDER_LAST: sender_last_cfg = value[PRIO_W-1:0];
      CFG_QUANTUM:     quantum_cfg     = value;
      default: ;
    endcase
  endtask

  task automatic program_regs(input int best, input int worst, input int base, input int rf,
                              input int rl, input int sl, input logic [31:0] q);
    write_reg(CFG_BEST_PRIO, CFG_DATA_W'(best));
    write_reg(CFG_WORST_PRIO, CFG_DATA_W'(worst));
    write_reg(CFG_BASE_PRIO, CFG_DATA_W'(base));
    write_reg(CFG_RECV_FIRST, CFG_DATA_W'(rf));
    write_reg(CFG_RECV_LAST, CFG_DATA_W'(rl));
    write_reg(CFG_SENDER_LAST, CFG_DATA_W'(sl));
    write_reg(CFG_QUANTUM, q);
  endtask

  task automatic settle();
    do @(negedge clk); while (op_q.size() != 0 || in_ch.valid || report_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // offer words and predict each one at its accept edge
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) report_q.push_back(apply_thread_op(offered_op));
      if (!in_ch.valid || in_ch.ready) begin
        if (op_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
          offered_op = op_q.pop_front();
          in_ch.valid         <= 1'b1;
          in_ch.func          <= offered_op.func;
          in_ch.thread_id     <= offered_op.thread_id;
          in_ch.dest_thread   <= offered_op.dest_thread;
          in_ch.init_priority <= offered_op.init_priority;
          in_ch.work_left     <= offered_op.work_left;
          in_ch.lost_cpu      <= offered_op.lost_cpu;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (report_q.size() == 0) begin
          $error("result word with no prediction waiting");
          fail_count++;
        end else begin
          want = report_q.pop_front();
          if (out_ch.priority_out !== want.priority_out) begin
            $error("priority_out expected %0d actual %0d", want.priority_out,
                   out_ch.priority_out);
            fail_count++;
          end
          if (out_ch.slice_time !== want.slice_time) begin
            $error("slice_time expected %0d actual %0d", want.slice_time, out_ch.slice_time);
            fail_count++;
          end
          if (out_ch.work_after !== want.work_after) begin
            $error("work_after expected %0d actual %0d", want.work_after, out_ch.work_after);
            fail_count++;
          end
          if (out_ch.work_done !== want.work_done) begin
            $error("work_done expected %0d actual %0d", want.work_done, out_ch.work_done);
            fail_count++;
          end
          if (out_ch.prio_changed !== want.prio_changed) begin
            $error("prio_changed expected %0d actual %0d", want.prio_changed,
                   out_ch.prio_changed);
            fail_count++;
          end
        end
      end
      // hold off for a long stretch on request
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left <= HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_ch.valid         = 1'b0;
    in_ch.func          = FN_QUERY;
    in_ch.thread_id     = '0;
    in_ch.dest_thread   = '0;
    in_ch.init_priority = '0;
    in_ch.work_left     = '0;
    in_ch.lost_cpu      = 1'b0;
    out_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.idx          = CFG_BEST_PRIO;
    cfg_ch.data         = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        0: program_regs(0, 100, 50, 5, -3, 7, 32'd10000);
        1: program_regs(-512, 511, -512, 511, -512, 1, 32'hFFFF_FFFF);
        2: program_regs(40, 10, 511, -1, 2, -512, 32'd1);
        3: program_regs(-100, 100, 0, 3, -7, 0, 32'd0);
        4: program_regs(-20, 300, -300, 100, -100, 50, 32'd37);
        default: program_regs($urandom_range(1023) - 512, $urandom_range(1023) - 512,
                              $urandom_range(1023) - 512, $urandom_range(1023) - 512,
                              $urandom_range(1023) - 512, $urandom_range(1023) - 512,
                              $urandom_range(5000, 1));
      endcase
      @(negedge clk);
      snd_idle_pct = (ph < 2) ? 20 : (ph < 4) ? 79 : 0;
      rcv_idle_pct = (ph < 2) ? 79 : (ph < 4) ? 20 : 0;
      if (ph == 0) begin
        queue_op(make_op(FN_INIT, 0, 5, -512, 32'd0, 1'b0));
        queue_op(make_op(FN_INIT, 1, 0, 511, 32'hFFFF_FFFF, 1'b1));
        queue_op(make_op(FN_INIT, 2, 63, 0, 32'd0, 1'b0));
        queue_op(make_op(FN_CLEAR, 3, 0, -1, 32'd0, 1'b0));
        queue_op(make_op(FN_INIT, 63, 63, -1, 32'd0, 1'b0));
        queue_op(make_op(FN_SEND, 0, 0, 0, 32'd0, 1'b0));
        queue_op(make_op(FN_RECV_MISS, 1, 0, 0, 32'd0, 1'b0));
        queue_op(make_op(FN_RECV_HIT, 2, 0, 0, 32'd0, 1'b0));
        queue_op(make_op(FN_SEND, 3, 0, 0, 32'd0, 1'b0));
        queue_op(make_op(FN_RECV_HIT, 3, 0, 0, 32'd0, 1'b0));
        queue_op(make_op(FN_QUERY, 0, 0, 0, 32'd0, 1'b0));
        queue_op(make_op(FN_QUERY, 63, 0, 0, 32'd0, 1'b0));
        queue_op(make_op(FN_EXECUTE, 2, 0, 0, 32'd0, 1'b0));
        queue_op(make_op(FN_EXECUTE, 2, 0, 0, 32'hFFFF_FFFF, 1'b0));
        queue_op(make_op(FN_EXECUTE, 2, 0, 0, 32'd5, 1'b0));
        queue_op(make_op(FN_EXECUTE, 2, 0, 0, 32'd20000, 1'b0));
        queue_op(make_op(FN_EXECUTE, 3, 0, 0, 32'd3, 1'b1));
        queue_op(make_op(FN_EXECUTE, 3, 0, 0, 32'd10000, 1'b0));
        queue_op(make_op(FN_COPY, 2, 63, 0, 32'd0, 1'b0));
        queue_op(make_op(FN_COPY, 63, 63, 0, 32'd0, 1'b0));
        queue_op(make_op(FN_COPY, 1, 10, 0, 32'd0, 1'b0));
        queue_op(make_op(FN_QUERY, 10, 0, 0, 32'd0, 1'b0));
        queue_op(make_op(FN_EXECUTE, 63, 0, 0, 32'd1, 1'b0));
      end
      if (ph == 4) hold_req++;
      repeat (PHASE_ITEMS) queue_op(random_op());
    end

    settle();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && report_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/pbtt_pkg.sv
rtl/pbtt_in_if.sv
rtl/pbtt_out_if.sv
rtl/pbtt_cfg_if.sv
rtl/pbtt_ram.sv
rtl/priority_boost_thread_table_core.sv
verif/tb_priority_boost_thread_table_core.sv
